[src/ebvm_pkg.sv]
// ---------------------------------------------------------------------------
// ebvm_pkg
// Shared constants and the hex font table for the 8-bit vm instruction core.
// ---------------------------------------------------------------------------
package ebvm_pkg;

    localparam int ADDR_W     = 12;
    localparam int REG_IDX_W  = 4;
    localparam int ROW_IDX_W  = 5;
    localparam int ROW_W      = 64;
    localparam int COL_IDX_W  = 6;
    localparam int GLYPH_SIZE = 80;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [7:0]        byte_t;
    typedef logic [ROW_W-1:0]  row_t;

    // operation codes of an input transaction
    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_EXEC = 2'd1;
    localparam logic [1:0] OP_ROW  = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_BADOP = 2'd1;
    localparam logic [1:0] ST_STACK = 2'd2;

    // instruction groups (top nibble)
    localparam logic [3:0] GRP_SYS   = 4'h0;
    localparam logic [3:0] GRP_JMP   = 4'h1;
    localparam logic [3:0] GRP_CALL  = 4'h2;
    localparam logic [3:0] GRP_SEQI  = 4'h3;
    localparam logic [3:0] GRP_SNEI  = 4'h4;
    localparam logic [3:0] GRP_SEQR  = 4'h5;
    localparam logic [3:0] GRP_LDI   = 4'h6;
    localparam logic [3:0] GRP_ADDI  = 4'h7;
    localparam logic [3:0] GRP_ALU   = 4'h8;
    localparam logic [3:0] GRP_SNER  = 4'h9;
    localparam logic [3:0] GRP_LDIDX = 4'hA;
    localparam logic [3:0] GRP_JMPV0 = 4'hB;
    localparam logic [3:0] GRP_RND   = 4'hC;
    localparam logic [3:0] GRP_DRAW  = 4'hD;
    localparam logic [3:0] GRP_MISC  = 4'hF;

    // alu sub-operations
    localparam logic [3:0] ALU_MOV = 4'h0;
    localparam logic [3:0] ALU_OR  = 4'h1;
    localparam logic [3:0] ALU_AND = 4'h2;
    localparam logic [3:0] ALU_XOR = 4'h3;
    localparam logic [3:0] ALU_ADD = 4'h4;
    localparam logic [3:0] ALU_SUB = 4'h5;
    localparam logic [3:0] ALU_SHR = 4'h6;
    localparam logic [3:0] ALU_RSB = 4'h7;
    localparam logic [3:0] ALU_SHL = 4'hE;

    localparam logic [11:0] SYS_CLS = 12'h0E0;
    localparam logic [11:0] SYS_RET = 12'h0EE;
    localparam logic [7:0]  MISC_GET_DT = 8'h07;
    localparam logic [7:0]  MISC_SET_DT = 8'h15;
    localparam logic [7:0]  MISC_SET_ST = 8'h18;

    localparam logic [REG_IDX_W-1:0] FLAG_REG = 4'hF;
    localparam logic [REG_IDX_W-1:0] ZERO_REG = 4'h0;

    // hex font glyphs, five bytes each
    function automatic byte_t font_byte(input logic [6:0] idx);
        byte_t b;
        case (idx)
            7'd0:  b = 8'hF0; 7'd1:  b = 8'h90; 7'd2:  b = 8'h90; 7'd3:  b = 8'h90;
            7'd4:  b = 8'hF0; 7'd5:  b = 8'h20; 7'd6:  b = 8'h60; 7'd7:  b = 8'h20;
            7'd8:  b = 8'h20; 7'd9:  b = 8'h70; 7'd10: b = 8'hF0; 7'd11: b = 8'h10;
            7'd12: b = 8'hF0; 7'd13: b = 8'h80; 7'd14: b = 8'hF0; 7'd15: b = 8'hF0;
            7'd16: b = 8'h10; 7'd17: b = 8'hF0; 7'd18: b = 8'h10; 7'd19: b = 8'hF0;
            7'd20: b = 8'h90; 7'd21: b = 8'h90; 7'd22: b = 8'hF0; 7'd23: b = 8'h10;
            7'd24: b = 8'h10; 7'd25: b = 8'hF0; 7'd26: b = 8'h80; 7'd27: b = 8'hF0;
            7'd28: b = 8'h10; 7'd29: b = 8'hF0; 7'd30: b = 8'hF0; 7'd31: b = 8'h80;
            7'd32: b = 8'hF0; 7'd33: b = 8'h90; 7'd34: b = 8'hF0; 7'd35: b = 8'hF0;
            7'd36: b = 8'h10; 7'd37: b = 8'h20; 7'd38: b = 8'h40; 7'd39: b = 8'h40;
            7'd40: b = 8'hF0; 7'd41: b = 8'h90; 7'd42: b = 8'hF0; 7'd43: b = 8'h90;
            7'd44: b = 8'hF0; 7'd45: b = 8'hF0; 7'd46: b = 8'h90; 7'd47: b = 8'hF0;
            7'd48: b = 8'h10; 7'd49: b = 8'hF0; 7'd50: b = 8'hF0; 7'd51: b = 8'h90;
            7'd52: b = 8'hF0; 7'd53: b = 8'h90; 7'd54: b = 8'h90; 7'd55: b = 8'hE0;
            7'd56: b = 8'h90; 7'd57: b = 8'hE0; 7'd58: b = 8'h90; 7'd59: b = 8'hE0;
            7'd60: b = 8'hF0; 7'd61: b = 8'h80; 7'd62: b = 8'h80; 7'd63: b = 8'h80;
            7'd64: b = 8'hF0; 7'd65: b = 8'hE0; 7'd66: b = 8'h90; 7'd67: b = 8'h90;
            7'd68: b = 8'h90; 7'd69: b = 8'hE0; 7'd70: b = 8'hF0; 7'd71: b = 8'h80;
            7'd72: b = 8'hF0; 7'd73: b = 8'h80; 7'd74: b = 8'hF0; 7'd75: b = 8'hF0;
            7'd76: b = 8'h80; 7'd77: b = 8'hF0; 7'd78: b = 8'h80; 7'd79: b = 8'h80;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // write request into a register-style memory
    typedef struct packed {
        logic                 we;
        logic [REG_IDX_W-1:0] addr;
        byte_t                data;
    } reg_wr_t;

endpackage

[src/ebvm_byte_mem.sv]
// ---------------------------------------------------------------------------
// ebvm_byte_mem
// 4 KiB byte memory, one write and one registered read port; after reset a
// sweep writes the font and zeros everywhere else, one byte per cycle.
// ---------------------------------------------------------------------------
module ebvm_byte_mem #(
    parameter int FONT_BASE = 80
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           we,
    input  ebvm_pkg::addr_t waddr,
    input  ebvm_pkg::byte_t wdata,
    input  ebvm_pkg::addr_t raddr,
    output ebvm_pkg::byte_t rdata,
    output logic           clearing
);

    localparam int DEPTH = 1 << ebvm_pkg::ADDR_W;

    ebvm_pkg::byte_t mem [DEPTH];
    ebvm_pkg::byte_t rdata_reg;
    logic [ebvm_pkg::ADDR_W:0] clr_reg;
    logic [ebvm_pkg::ADDR_W:0] clr_next;
    logic [ebvm_pkg::ADDR_W:0] font_off;
    ebvm_pkg::byte_t clr_data;

    assign clearing = ~clr_reg[ebvm_pkg::ADDR_W];
    assign clr_next = clr_reg + 1'b1;

    // font contents for the sweep
    always_comb
    begin
        font_off = clr_reg - (ebvm_pkg::ADDR_W + 1)'(FONT_BASE);
        if (!font_off[ebvm_pkg::ADDR_W] &&
            font_off < (ebvm_pkg::ADDR_W + 1)'(ebvm_pkg::GLYPH_SIZE))
        begin
            clr_data = ebvm_pkg::font_byte(font_off[6:0]);
        end
        else
        begin
            clr_data = 8'h00;
        end
    end

    // sweep counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else if (clearing)
        begin
            clr_reg <= clr_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (clearing)
        begin
            mem[clr_reg[ebvm_pkg::ADDR_W-1:0]] <= clr_data;
        end
        else if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[src/ebvm_reg_file.sv]
// ---------------------------------------------------------------------------
// ebvm_reg_file
// Sixteen byte registers in a small memory with per-entry valid bits and a
// shadow copy of the flag register.
// ---------------------------------------------------------------------------
module ebvm_reg_file (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  ebvm_pkg::reg_wr_t                    wr,
    input  logic [ebvm_pkg::REG_IDX_W-1:0]       raddr,
    output ebvm_pkg::byte_t                      rdata,
    output ebvm_pkg::byte_t                      vf
);

    ebvm_pkg::byte_t mem [16];
    ebvm_pkg::byte_t mem_q_reg;
    logic [15:0]     vld_reg;
    logic            vld_q_reg;
    ebvm_pkg::byte_t vf_reg;

    // valid bits and flag shadow
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= '0;
            vld_q_reg <= 1'b0;
            vf_reg    <= '0;
        end
        else
        begin
            vld_q_reg <= vld_reg[raddr];
            if (wr.we)
            begin
                vld_reg[wr.addr] <= 1'b1;
                if (wr.addr == ebvm_pkg::FLAG_REG)
                begin
                    vf_reg <= wr.data;
                end
            end
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.addr] <= wr.data;
        end
        mem_q_reg <= mem[raddr];
    end

    assign rdata = vld_q_reg ? mem_q_reg : 8'h00;
    assign vf    = vf_reg;

endmodule

[src/ebvm_frame_mem.sv]
// ---------------------------------------------------------------------------
// ebvm_frame_mem
// 32 screen rows of 64 pixels; valid bits give the cleared state at once.
// ---------------------------------------------------------------------------
module ebvm_frame_mem (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           clear_all,
    input  logic                           we,
    input  logic [ebvm_pkg::ROW_IDX_W-1:0] waddr,
    input  ebvm_pkg::row_t                 wdata,
    input  logic [ebvm_pkg::ROW_IDX_W-1:0] raddr,
    output ebvm_pkg::row_t                 rdata
);

    localparam int ROWS = 1 << ebvm_pkg::ROW_IDX_W;

    ebvm_pkg::row_t mem [ROWS];
    ebvm_pkg::row_t mem_q_reg;
    logic [ROWS-1:0] vld_reg;
    logic            vld_q_reg;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= '0;
            vld_q_reg <= 1'b0;
        end
        else
        begin
            vld_q_reg <= vld_reg[raddr];
            if (clear_all)
            begin
                vld_reg <= '0;
            end
            else if (we)
            begin
                vld_reg[waddr] <= 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        mem_q_reg <= mem[raddr];
    end

    assign rdata = vld_q_reg ? mem_q_reg : '0;

endmodule

[src/eight_bit_vm_instruction_core.sv]
// ---------------------------------------------------------------------------
// eight_bit_vm_instruction_core
// Path from accept to result strobe: a load or row read goes S_ROW, S_RESP;
// an instruction goes S_F1, S_F2, S_R1, S_R2, S_EX, then S_D0/S_D1 per drawn
// row (up to 15) for a draw, S_WF if it writes the flag or S_RET if it returns, then S_ROW, S_RESP.
// One transaction at a time, next one accepted the cycle after the strobe.
// Reset: after rst_n releases, a 4096-cycle sweep loads the font into the
// byte memory; busy stays high until it ends. Results cannot be stalled.
// ---------------------------------------------------------------------------
module eight_bit_vm_instruction_core #(
    parameter int STACK_DEPTH   = 16,
    parameter int FONT_BASE     = 80,
    parameter int PROGRAM_START = 512
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  op,
    input  logic [11:0] address,
    input  logic [7:0]  data_byte,
    input  logic [7:0]  random_byte,
    input  logic [4:0]  row_select,
    output logic        done,
    output logic [1:0]  status,
    output logic [11:0] program_counter,
    output logic [11:0] index_value,
    output logic [7:0]  flag_value,
    output logic [63:0] screen_row
);

    localparam int SP_W  = $clog2(STACK_DEPTH + 1);
    localparam int STK_W = $clog2(STACK_DEPTH);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_F1   = 4'd1;
    localparam logic [3:0] S_F2   = 4'd2;
    localparam logic [3:0] S_R1   = 4'd3;
    localparam logic [3:0] S_R2   = 4'd4;
    localparam logic [3:0] S_EX   = 4'd5;
    localparam logic [3:0] S_RET  = 4'd6;
    localparam logic [3:0] S_WF   = 4'd7;
    localparam logic [3:0] S_D0   = 4'd8;
    localparam logic [3:0] S_D1   = 4'd9;
    localparam logic [3:0] S_ROW  = 4'd10;
    localparam logic [3:0] S_RESP = 4'd11;

    logic [3:0]  state_reg, state_next;
    logic [11:0] pc_reg, pc_next;
    logic [11:0] idx_reg, idx_next;
    logic [SP_W-1:0] sp_reg, sp_next;
    logic [7:0]  dt_reg, dt_next;
    logic [7:0]  snd_reg, snd_next;
    logic [1:0]  status_reg, status_next;
    logic [15:0] opc_reg, opc_next;
    logic [7:0]  vx_reg, vx_next;
    logic [7:0]  vy_reg, vy_next;
    logic [7:0]  rnd_reg, rnd_next;
    logic [4:0]  row_reg, row_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic        hit_reg, hit_next;
    logic [7:0]  wf_reg, wf_next;

    // memory controls
    logic            b_we;
    logic [11:0]     b_waddr, b_raddr;
    logic [7:0]      b_wdata, b_rdata;
    logic            b_clearing;
    ebvm_pkg::reg_wr_t r_wr;
    logic [3:0]      r_raddr;
    logic [7:0]      r_rdata, vf;
    logic            f_clr, f_we;
    logic [4:0]      f_waddr, f_raddr;
    logic [63:0]     f_wdata, f_rdata;
    logic            stk_we;
    logic [STK_W-1:0] stk_addr;
    logic [11:0]     stk_mem [STACK_DEPTH];
    logic [11:0]     stk_q_reg;

    // decode and datapath temporaries
    logic [3:0]  f_grp, f_x, f_y, f_n;
    logic [7:0]  f_nn;
    logic [11:0] f_nnn;
    logic [8:0]  sum9;
    logic [5:0]  line;
    logic [63:0] sprite_bits;

    assign f_grp = opc_reg[15:12];
    assign f_x   = opc_reg[11:8];
    assign f_y   = opc_reg[7:4];
    assign f_n   = opc_reg[3:0];
    assign f_nn  = opc_reg[7:0];
    assign f_nnn = opc_reg[11:0];
    assign sum9  = {1'b0, vx_reg} + {1'b0, vy_reg};
    assign line  = {1'b0, vy_reg[4:0]} + {2'b00, cnt_reg};
    assign sprite_bits = {b_rdata, 56'd0} >> vx_reg[5:0];

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        pc_next     = pc_reg;
        idx_next    = idx_reg;
        sp_next     = sp_reg;
        dt_next     = dt_reg;
        snd_next    = snd_reg;
        status_next = status_reg;
        opc_next    = opc_reg;
        vx_next     = vx_reg;
        vy_next     = vy_reg;
        rnd_next    = rnd_reg;
        row_next    = row_reg;
        cnt_next    = cnt_reg;
        hit_next    = hit_reg;
        wf_next     = wf_reg;
        b_we        = 1'b0;
        b_waddr     = address;
        b_wdata     = data_byte;
        b_raddr     = pc_reg;
        r_wr        = '0;
        r_raddr     = f_x;
        f_clr       = 1'b0;
        f_we        = 1'b0;
        f_waddr     = line[4:0];
        f_wdata     = f_rdata ^ sprite_bits;
        f_raddr     = row_reg;
        stk_we      = 1'b0;
        stk_addr    = sp_reg[STK_W-1:0];
        case (state_reg)
            S_IDLE:
            begin
                if (start && !b_clearing)
                begin
                    status_next = ebvm_pkg::ST_OK;
                    row_next    = row_select;
                    rnd_next    = random_byte;
                    state_next  = S_ROW;
                    case (op)
                        ebvm_pkg::OP_LOAD: b_we = 1'b1;
                        ebvm_pkg::OP_EXEC: state_next = S_F1;
                        ebvm_pkg::OP_ROW:  state_next = S_ROW;
                        default:           status_next = ebvm_pkg::ST_BADOP;
                    endcase
                end
            end
            S_F1:
            begin
                b_raddr        = pc_reg + 12'd1;
                opc_next[15:8] = b_rdata;
                state_next     = S_F2;
            end
            S_F2:
            begin
                opc_next[7:0] = b_rdata;
                pc_next       = pc_reg + 12'd2;
                r_raddr       = f_x;
                state_next    = S_R1;
            end
            S_R1:
            begin
                r_raddr    = f_y;
                vx_next    = r_rdata;
                state_next = S_R2;
            end
            S_R2:
            begin
                r_raddr    = ebvm_pkg::ZERO_REG;
                vy_next    = r_rdata;
                state_next = S_EX;
            end
            S_EX:
            begin
                state_next = S_ROW;
                r_wr.addr  = f_x;
                case (f_grp)
                    ebvm_pkg::GRP_SYS:
                    begin
                        if (f_nnn == ebvm_pkg::SYS_CLS)
                        begin
                            f_clr = 1'b1;
                        end
                        else if (f_nnn == ebvm_pkg::SYS_RET)
                        begin
                            if (sp_reg == '0)
                            begin
                                status_next = ebvm_pkg::ST_STACK;
                            end
                            else
                            begin
                                sp_next    = sp_reg - 1'b1;
                                stk_addr   = sp_next[STK_W-1:0];
                                state_next = S_RET;
                            end
                        end
                        else
                        begin
                            status_next = ebvm_pkg::ST_BADOP;
                        end
                    end
                    ebvm_pkg::GRP_JMP: pc_next = f_nnn;
                    ebvm_pkg::GRP_CALL:
                    begin
                        if (sp_reg >= SP_W'(STACK_DEPTH))
                        begin
                            status_next = ebvm_pkg::ST_STACK;
                        end
                        else
                        begin
                            stk_we  = 1'b1;
                            sp_next = sp_reg + 1'b1;
                            pc_next = f_nnn;
                        end
                    end
                    ebvm_pkg::GRP_SEQI:
                        if (vx_reg == f_nn) pc_next = pc_reg + 12'd2;
                    ebvm_pkg::GRP_SNEI:
                        if (vx_reg != f_nn) pc_next = pc_reg + 12'd2;
                    ebvm_pkg::GRP_SEQR:
                        if (vx_reg == vy_reg) pc_next = pc_reg + 12'd2;
                    ebvm_pkg::GRP_SNER:
                        if (vx_reg != vy_reg) pc_next = pc_reg + 12'd2;
                    ebvm_pkg::GRP_LDI:
                    begin
                        r_wr.we   = 1'b1;
                        r_wr.data = f_nn;
                    end
                    ebvm_pkg::GRP_ADDI:
                    begin
                        r_wr.we   = 1'b1;
                        r_wr.data = vx_reg + f_nn;
                    end
                    ebvm_pkg::GRP_ALU:
                    begin
                        r_wr.we    = 1'b1;
                        state_next = S_WF;
                        case (f_n)
                            ebvm_pkg::ALU_MOV:
                            begin
                                r_wr.data  = vy_reg;
                                state_next = S_ROW;
                            end
                            ebvm_pkg::ALU_OR:
                            begin
                                r_wr.data  = vx_reg | vy_reg;
                                state_next = S_ROW;
                            end
                            ebvm_pkg::ALU_AND:
                            begin
                                r_wr.data  = vx_reg & vy_reg;
                                state_next = S_ROW;
                            end
                            ebvm_pkg::ALU_XOR:
                            begin
                                r_wr.data  = vx_reg ^ vy_reg;
                                state_next = S_ROW;
                            end
                            ebvm_pkg::ALU_ADD:
                            begin
                                r_wr.data = sum9[7:0];
                                wf_next   = {7'd0, sum9[8]};
                            end
                            ebvm_pkg::ALU_SUB:
                            begin
                                r_wr.data = vx_reg - vy_reg;
                                wf_next   = {7'd0, vx_reg >= vy_reg};
                            end
                            ebvm_pkg::ALU_SHR:
                            begin
                                r_wr.data = {1'b0, vx_reg[7:1]};
                                wf_next   = {7'd0, vx_reg[0]};
                            end
                            ebvm_pkg::ALU_RSB:
                            begin
                                r_wr.data = vy_reg - vx_reg;
                                wf_next   = {7'd0, vy_reg >= vx_reg};
                            end
                            ebvm_pkg::ALU_SHL:
                            begin
                                r_wr.data = {vx_reg[6:0], 1'b0};
                                wf_next   = {7'd0, vx_reg[7]};
                            end
                            default:
                            begin
                                r_wr.we     = 1'b0;
                                status_next = ebvm_pkg::ST_BADOP;
                                state_next  = S_ROW;
                            end
                        endcase
                    end
                    ebvm_pkg::GRP_LDIDX: idx_next = f_nnn;
                    ebvm_pkg::GRP_JMPV0: pc_next = f_nnn + {4'd0, r_rdata};
                    ebvm_pkg::GRP_RND:
                    begin
                        r_wr.we   = 1'b1;
                        r_wr.data = rnd_reg & f_nn;
                    end
                    ebvm_pkg::GRP_DRAW:
                    begin
                        cnt_next   = '0;
                        hit_next   = 1'b0;
                        state_next = S_D0;
                    end
                    ebvm_pkg::GRP_MISC:
                    begin
                        if (f_nn == ebvm_pkg::MISC_GET_DT)
                        begin
                            r_wr.we   = 1'b1;
                            r_wr.data = dt_reg;
                        end
                        else if (f_nn == ebvm_pkg::MISC_SET_DT)
                        begin
                            dt_next = vx_reg;
                        end
                        else if (f_nn == ebvm_pkg::MISC_SET_ST)
                        begin
                            snd_next = vx_reg;
                        end
                        else
                        begin
                            status_next = ebvm_pkg::ST_BADOP;
                        end
                    end
                    default: status_next = ebvm_pkg::ST_BADOP;
                endcase
            end
            S_RET:
            begin
                pc_next    = stk_q_reg;
                state_next = S_ROW;
            end
            S_WF:
            begin
                r_wr.we    = 1'b1;
                r_wr.addr  = ebvm_pkg::FLAG_REG;
                r_wr.data  = wf_reg;
                state_next = S_ROW;
            end
            S_D0:
            begin
                if (cnt_reg == f_n || line[5])
                begin
                    wf_next    = {7'd0, hit_reg};
                    state_next = S_WF;
                end
                else
                begin
                    b_raddr    = idx_reg + {8'd0, cnt_reg};
                    f_raddr    = line[4:0];
                    state_next = S_D1;
                end
            end
            S_D1:
            begin
                f_we       = 1'b1;
                hit_next   = hit_reg | (|(f_rdata & sprite_bits));
                cnt_next   = cnt_reg + 4'd1;
                state_next = S_D0;
            end
            S_ROW:
            begin
                f_raddr    = row_reg;
                state_next = S_RESP;
            end
            S_RESP:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control and architectural registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            pc_reg     <= 12'(PROGRAM_START);
            idx_reg    <= '0;
            sp_reg     <= '0;
            dt_reg     <= '0;
            snd_reg    <= '0;
            status_reg <= ebvm_pkg::ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            pc_reg     <= pc_next;
            idx_reg    <= idx_next;
            sp_reg     <= sp_next;
            dt_reg     <= dt_next;
            snd_reg    <= snd_next;
            status_reg <= status_next;
        end
    end

    // working payload registers
    always_ff @(posedge clk)
    begin
        opc_reg <= opc_next;
        vx_reg  <= vx_next;
        vy_reg  <= vy_next;
        rnd_reg <= rnd_next;
        row_reg <= row_next;
        cnt_reg <= cnt_next;
        hit_reg <= hit_next;
        wf_reg  <= wf_next;
    end

    // return stack memory
    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stk_mem[stk_addr] <= pc_reg;
        end
        stk_q_reg <= stk_mem[stk_addr];
    end

    ebvm_byte_mem #(
        .FONT_BASE(FONT_BASE)
    ) u_byte_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .we       (b_we),
        .waddr    (b_waddr),
        .wdata    (b_wdata),
        .raddr    (b_raddr),
        .rdata    (b_rdata),
        .clearing (b_clearing)
    );

    ebvm_reg_file u_reg_file (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (r_wr),
        .raddr (r_raddr),
        .rdata (r_rdata),
        .vf    (vf)
    );

    ebvm_frame_mem u_frame_mem (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear_all (f_clr),
        .we        (f_we),
        .waddr     (f_waddr),
        .wdata     (f_wdata),
        .raddr     (f_raddr),
        .rdata     (f_rdata)
    );

    // result ports
    assign busy            = (state_reg != S_IDLE) || b_clearing;
    assign done            = (state_reg == S_RESP);
    assign status          = status_reg;
    assign program_counter = pc_reg;
    assign index_value     = idx_reg;
    assign flag_value      = vf;
    assign screen_row      = f_rdata;

    // checks
    a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= SP_W'(STACK_DEPTH))
        else $error("stack pointer beyond depth");
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");
    a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
        b_clearing |-> (busy && !done))
        else $error("activity during memory sweep");
    a_draw_write: assert property (@(posedge clk) disable iff (!rst_n)
        f_we |-> $past(state_reg == S_D0))
        else $error("frame write outside sprite draw");

endmodule
